>>> design/tlpq_pkg.sv
package tlpq_pkg;

  // Field widths of one request and one result
  localparam int ID_W     = 31;
  localparam int CODE_W   = 8;
  localparam int QTY_W    = 20;
  localparam int PRICE_W  = 32;
  localparam int REV_W    = 52;
  localparam int STATUS_W = 2;
  localparam int RANK_W   = 2;
  localparam int LEVELS   = 3;

  // Operation codes of a request
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Rank codes
  localparam logic [RANK_W-1:0] RANK_NONE    = 2'd0;
  localparam logic [RANK_W-1:0] RANK_BEST    = 2'd1;
  localparam logic [RANK_W-1:0] RANK_DEFAULT = 2'd2;
  localparam logic [RANK_W-1:0] RANK_LOW     = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic exec;       // update the level queues and start the store access
    logic read_done;  // store read data is valid, form the product
    logic load_out;   // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_read;  // the latched request is a dequeue of a non-empty queue
    logic out_free;   // the output register can take a result this cycle
  } stat_t;

  // Any code outside the defined ranks falls back to the default rank.
  function automatic logic [RANK_W-1:0] rank_of(input logic [CODE_W-1:0] code);
    logic [RANK_W-1:0] r;
    if (code >= CODE_W'(RANK_BEST) && code <= CODE_W'(RANK_LOW)) begin
      r = code[RANK_W-1:0];
    end else begin
      r = RANK_DEFAULT;
    end
    return r;
  endfunction

endpackage

>>> design/tlpq_ctrl.sv
module tlpq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlpq_pkg::stat_t stat,
  output tlpq_pkg::cmd_t  cmd
);
  import tlpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // A new request is taken only when the previous one has left for the output register.
  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_read ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd.read_done = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/tlpq_dp.sv
module tlpq_dp #(
  parameter int LEVEL_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_op,
  input  logic [tlpq_pkg::ID_W-1:0]      in_order_id,
  input  logic [tlpq_pkg::CODE_W-1:0]    in_priority_code,
  input  logic [tlpq_pkg::QTY_W-1:0]     in_quantity,
  input  logic [tlpq_pkg::PRICE_W-1:0]   in_unit_price,
  input  tlpq_pkg::cmd_t                 cmd,
  output tlpq_pkg::stat_t                stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tlpq_pkg::STATUS_W-1:0]  out_status,
  output logic [tlpq_pkg::ID_W-1:0]      out_order_id,
  output logic [tlpq_pkg::RANK_W-1:0]    out_rank,
  output logic [tlpq_pkg::QTY_W-1:0]     out_quantity,
  output logic [tlpq_pkg::PRICE_W-1:0]   out_price,
  output logic [tlpq_pkg::REV_W-1:0]     out_revenue
);
  import tlpq_pkg::*;

  localparam int LW     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CW     = $clog2(LEVEL_DEPTH + 1);
  localparam int DEPTH  = LEVELS * LEVEL_DEPTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = ID_W + QTY_W + PRICE_W;
  localparam logic [AW-1:0] BASE1 = AW'(LEVEL_DEPTH);
  localparam logic [AW-1:0] BASE2 = AW'(2 * LEVEL_DEPTH);

  // Latched request
  logic                op_r;
  logic [ID_W-1:0]     id_r;
  logic [RANK_W-1:0]   rank_r;
  logic [QTY_W-1:0]    qty_r;
  logic [PRICE_W-1:0]  price_r;

  // Per-level ring pointers
  logic [LW-1:0] head_r [LEVELS];
  logic [CW-1:0] cnt_r  [LEVELS];

  // Item store, one ring of LEVEL_DEPTH words per level
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;

  // Result staging and output registers
  logic [STATUS_W-1:0] res_status_r;
  logic [RANK_W-1:0]   res_rank_r;
  logic [ID_W-1:0]     res_id_r;
  logic [QTY_W-1:0]    res_qty_r;
  logic [PRICE_W-1:0]  res_price_r;
  logic [REV_W-1:0]    res_rev_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [RANK_W-1:0]   out_rank_r;
  logic [ID_W-1:0]     out_id_r;
  logic [QTY_W-1:0]    out_qty_r;
  logic [PRICE_W-1:0]  out_price_r;
  logic [REV_W-1:0]    out_rev_r;

  logic [1:0]        enq_lv;
  logic [1:0]        deq_lv;
  logic              enq_full;
  logic              any_held;
  logic [LW:0]       slot_sum;
  logic [LW-1:0]     slot;
  logic [LW-1:0]     head_inc;
  logic [ID_W-1:0]   rd_id;
  logic [QTY_W-1:0]  rd_qty;
  logic [PRICE_W-1:0] rd_price;
  logic [REV_W-1:0]  product;

  function automatic logic [AW-1:0] level_base(input logic [1:0] lv);
    logic [AW-1:0] b;
    unique case (lv)
      2'd0:    b = '0;
      2'd1:    b = BASE1;
      default: b = BASE2;
    endcase
    return b;
  endfunction

  // Capture the accepted request, with the rank already normalised
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      id_r    <= in_order_id;
      rank_r  <= rank_of(in_priority_code);
      qty_r   <= in_quantity;
      price_r <= in_unit_price;
    end
  end

  // Level selection: enqueue by its rank, dequeue by the best non-empty level
  assign enq_lv   = rank_r - 2'd1;
  assign enq_full = (cnt_r[enq_lv] == CW'(LEVEL_DEPTH));
  assign any_held = (cnt_r[0] != '0) || (cnt_r[1] != '0) || (cnt_r[2] != '0);

  always_comb begin
    if (cnt_r[0] != '0) begin
      deq_lv = 2'd0;
    end else if (cnt_r[1] != '0) begin
      deq_lv = 2'd1;
    end else begin
      deq_lv = 2'd2;
    end
  end

  // Tail slot of the ring and the advanced head pointer
  assign slot_sum = {1'b0, head_r[enq_lv]} + {1'b0, cnt_r[enq_lv][LW-1:0]};
  assign slot     = (slot_sum >= (LW+1)'(LEVEL_DEPTH)) ?
                    LW'(slot_sum - (LW+1)'(LEVEL_DEPTH)) : slot_sum[LW-1:0];
  assign head_inc = (head_r[deq_lv] == LW'(LEVEL_DEPTH - 1)) ?
                    '0 : head_r[deq_lv] + LW'(1);

  assign mem_we   = cmd.exec && (op_r == OP_ENQ) && !enq_full;
  assign mem_re   = cmd.exec && (op_r == OP_DEQ) && any_held;
  assign mem_addr = (op_r == OP_ENQ) ? level_base(enq_lv) + AW'(slot)
                                     : level_base(deq_lv) + AW'(head_r[deq_lv]);

  // Store with one shared port and registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {id_r, qty_r, price_r};
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (mem_we) begin
      cnt_r[enq_lv] <= cnt_r[enq_lv] + CW'(1);
    end else if (mem_re) begin
      head_r[deq_lv] <= head_inc;
      cnt_r[deq_lv]  <= cnt_r[deq_lv] - CW'(1);
    end
  end

  // Revenue from the registered read word
  assign {rd_id, rd_qty, rd_price} = rdata_r;
  assign product = rd_price * rd_qty;

  // Result staging
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_id_r    <= '0;
      res_qty_r   <= '0;
      res_price_r <= '0;
      res_rev_r   <= '0;
      if (op_r == OP_ENQ) begin
        res_status_r <= enq_full ? ST_FULL : ST_DONE;
        res_rank_r   <= rank_r;
      end else if (any_held) begin
        res_status_r <= ST_DONE;
        res_rank_r   <= deq_lv + 2'd1;
      end else begin
        res_status_r <= ST_EMPTY;
        res_rank_r   <= RANK_NONE;
      end
    end else if (cmd.read_done) begin
      res_id_r    <= rd_id;
      res_qty_r   <= rd_qty;
      res_price_r <= rd_price;
      res_rev_r   <= product;
    end
  end

  // Output register, free once its result has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_rank_r   <= res_rank_r;
      out_id_r     <= res_id_r;
      out_qty_r    <= res_qty_r;
      out_price_r  <= res_price_r;
      out_rev_r    <= res_rev_r;
    end
  end

  assign stat.need_read = (op_r == OP_DEQ) && any_held;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_order_id = out_id_r;
  assign out_rank     = out_rank_r;
  assign out_quantity = out_qty_r;
  assign out_price    = out_price_r;
  assign out_revenue  = out_rev_r;

endmodule

>>> design/three_level_stable_priority_queue.sv
// Three-level stable priority queue with one FIFO ring per rank in a single-port
// store. Each request gives one result. A request is latched when it is accepted;
// its status is staged in the EXEC state and moved into the output register from
// the DONE state for an enqueue or a dequeue of an empty queue, while a dequeue
// that returns an item passes through the READ state in between, because the store
// read is registered. One request is worked on at a time, so a new one is taken
// as soon as the previous result has moved into the output register, even if it
// is not yet taken; a result that finds the output register still full waits, and
// so does the input.
module three_level_stable_priority_queue #(
  parameter int LEVEL_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [tlpq_pkg::ID_W-1:0]     in_order_id,
  input  logic [tlpq_pkg::CODE_W-1:0]   in_priority_code,
  input  logic [tlpq_pkg::QTY_W-1:0]    in_quantity,
  input  logic [tlpq_pkg::PRICE_W-1:0]  in_unit_price,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlpq_pkg::STATUS_W-1:0] out_status,
  output logic [tlpq_pkg::ID_W-1:0]     out_order_id,
  output logic [tlpq_pkg::RANK_W-1:0]   out_rank,
  output logic [tlpq_pkg::QTY_W-1:0]    out_quantity,
  output logic [tlpq_pkg::PRICE_W-1:0]  out_price,
  output logic [tlpq_pkg::REV_W-1:0]    out_revenue
);
  import tlpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of each request
  tlpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Level queues, store and result registers
  tlpq_dp #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_order_id      (in_order_id),
    .in_priority_code (in_priority_code),
    .in_quantity      (in_quantity),
    .in_unit_price    (in_unit_price),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_order_id     (out_order_id),
    .out_rank         (out_rank),
    .out_quantity     (out_quantity),
    .out_price        (out_price),
    .out_revenue      (out_revenue)
  );

  // A result is only moved into the output register when that register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over an untaken result");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready)
    else $error("request accepted while another is in flight");

  // An empty dequeue carries no rank and no revenue.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_rank == RANK_NONE && out_revenue == '0))
    else $error("empty dequeue result carries data");

  // Every other result names a rank.
  a_rank_named: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_EMPTY) |-> (out_rank != RANK_NONE))
    else $error("result without a rank");

endmodule

>>> tb/tlpq_order_checker.sv
`timescale 1ns / 100ps

module tlpq_order_checker #(
  parameter int LEVEL_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_op,
  input  logic [tlpq_pkg::ID_W-1:0]     in_order_id,
  input  logic [tlpq_pkg::CODE_W-1:0]   in_priority_code,
  input  logic [tlpq_pkg::QTY_W-1:0]    in_quantity,
  input  logic [tlpq_pkg::PRICE_W-1:0]  in_unit_price,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tlpq_pkg::STATUS_W-1:0] out_status,
  input  logic [tlpq_pkg::ID_W-1:0]     out_order_id,
  input  logic [tlpq_pkg::RANK_W-1:0]   out_rank,
  input  logic [tlpq_pkg::QTY_W-1:0]    out_quantity,
  input  logic [tlpq_pkg::PRICE_W-1:0]  out_price,
  input  logic [tlpq_pkg::REV_W-1:0]    out_revenue,
  output int                            fail_count,
  output int                            pending_count
);
  import tlpq_pkg::*;

  typedef struct {
    status_t             status;
    logic [ID_W-1:0]     order_id;
    logic [RANK_W-1:0]   rank;
    logic [QTY_W-1:0]    quantity;
    logic [PRICE_W-1:0]  price;
    logic [REV_W-1:0]    revenue;
  } order_result_t;

  // Results owed by the block, oldest first.
  order_result_t expected_results[$];
  order_result_t oldest_result;
  order_result_t predicted_result;

  // Shadow copy of the three rank FIFOs.
  logic [ID_W-1:0]    held_id       [0:LEVELS-1][0:LEVEL_DEPTH-1];
  logic [QTY_W-1:0]   held_quantity [0:LEVELS-1][0:LEVEL_DEPTH-1];
  logic [PRICE_W-1:0] held_price    [0:LEVELS-1][0:LEVEL_DEPTH-1];
  int unsigned        level_head    [0:LEVELS-1];
  int unsigned        level_count   [0:LEVELS-1];

  // Codes other than the three defined ranks fall back to the default rank.
  function automatic logic [RANK_W-1:0] normalise_rank(input logic [CODE_W-1:0] code);
    if (code == CODE_W'(RANK_BEST) || code == CODE_W'(RANK_DEFAULT) ||
        code == CODE_W'(RANK_LOW)) begin
      return code[RANK_W-1:0];
    end
    return RANK_DEFAULT;
  endfunction

  // Applies one accepted request to the shadow queues and returns its result.
  function automatic order_result_t apply_order_request(
    input logic               op,
    input logic [ID_W-1:0]    id,
    input logic [CODE_W-1:0]  code,
    input logic [QTY_W-1:0]   qty,
    input logic [PRICE_W-1:0] price
  );
    order_result_t res;
    int unsigned   lvl;
    int unsigned   slot;
    res.status   = ST_DONE;
    res.order_id = '0;
    res.rank     = RANK_NONE;
    res.quantity = '0;
    res.price    = '0;
    res.revenue  = '0;
    if (op == OP_ENQ) begin
      res.rank = normalise_rank(code);
      lvl = res.rank - 1;
      if (level_count[lvl] >= LEVEL_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot = (level_head[lvl] + level_count[lvl]) % LEVEL_DEPTH;
        held_id[lvl][slot]       = id;
        held_quantity[lvl][slot] = qty;
        held_price[lvl][slot]    = price;
        level_count[lvl]++;
      end
    end else begin
      lvl = 0;
      while (lvl < LEVELS && level_count[lvl] == 0) begin
        lvl++;
      end
      if (lvl >= LEVELS) begin
        res.status = ST_EMPTY;
      end else begin
        slot = level_head[lvl];
        res.order_id = held_id[lvl][slot];
        res.quantity = held_quantity[lvl][slot];
        res.price    = held_price[lvl][slot];
        res.rank     = RANK_W'(lvl + 1);
        res.revenue  = REV_W'(res.price) * REV_W'(res.quantity);
        level_head[lvl] = (level_head[lvl] + 1) % LEVEL_DEPTH;
        level_count[lvl]--;
      end
    end
    return res;
  endfunction

  task automatic report_failure(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    fail_count++;
  endtask

  // Field by field comparison of the taken result with the oldest expectation.
  task automatic compare_result(input order_result_t exp);
    if (out_status !== exp.status)
      report_failure($sformatf("status got %0h, expected %0h", out_status, exp.status));
    if (out_order_id !== exp.order_id)
      report_failure($sformatf("order id got %0h, expected %0h", out_order_id, exp.order_id));
    if (out_rank !== exp.rank)
      report_failure($sformatf("rank got %0h, expected %0h", out_rank, exp.rank));
    if (out_quantity !== exp.quantity)
      report_failure($sformatf("quantity got %0h, expected %0h", out_quantity, exp.quantity));
    if (out_price !== exp.price)
      report_failure($sformatf("price got %0h, expected %0h", out_price, exp.price));
    if (out_revenue !== exp.revenue)
      report_failure($sformatf("revenue got %0h, expected %0h", out_revenue, exp.revenue));
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      for (int l = 0; l < LEVELS; l++) begin
        level_head[l]  = 0;
        level_count[l] = 0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_failure("result arrived with no request outstanding");
        end else begin
          oldest_result = expected_results.pop_front();
          compare_result(oldest_result);
        end
      end
      if (in_valid && in_ready) begin
        predicted_result = apply_order_request(in_op, in_order_id,
          in_priority_code, in_quantity, in_unit_price);
        expected_results.insert(expected_results.size(), predicted_result);
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

>>> tb/tb_three_level_stable_priority_queue.sv
`timescale 1ns / 100ps

module tb_three_level_stable_priority_queue;
  import tlpq_pkg::*;

  localparam int LEVEL_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {MIX_MODE, FILL_MODE, DRAIN_MODE, FLOOD_MODE} stim_mode_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_op            = OP_ENQ;
  logic [ID_W-1:0]     in_order_id      = '0;
  logic [CODE_W-1:0]   in_priority_code = '0;
  logic [QTY_W-1:0]    in_quantity      = '0;
  logic [PRICE_W-1:0]  in_unit_price    = '0;
  logic                out_ready        = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_order_id;
  logic [RANK_W-1:0]   out_rank;
  logic [QTY_W-1:0]    out_quantity;
  logic [PRICE_W-1:0]  out_price;
  logic [REV_W-1:0]    out_revenue;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int burst_left  = 0;
  int items_sent  = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;

  three_level_stable_priority_queue #(
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_order_id      (in_order_id),
    .in_priority_code (in_priority_code),
    .in_quantity      (in_quantity),
    .in_unit_price    (in_unit_price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_order_id     (out_order_id),
    .out_rank         (out_rank),
    .out_quantity     (out_quantity),
    .out_price        (out_price),
    .out_revenue      (out_revenue)
  );

  tlpq_order_checker #(
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_order_id      (in_order_id),
    .in_priority_code (in_priority_code),
    .in_quantity      (in_quantity),
    .in_unit_price    (in_unit_price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_order_id     (out_order_id),
    .out_rank         (out_rank),
    .out_quantity     (out_quantity),
    .out_price        (out_price),
    .out_revenue      (out_revenue),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Guard against a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // The result side picks a new random stall pattern whenever the current one runs out.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(30, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:         out_ready <= 1'b1;
      RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
      RX_EVERY_FOURTH: out_ready <= (rx_phase % 4 == 0);
      default:         out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Mostly random, with a fair share of all-zero and all-one values.
  function automatic logic [31:0] biased_value(input logic [31:0] max_value);
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return max_value;
    return $urandom() & max_value;
  endfunction

  // Offers one request, opening a gap first when the current burst has run out.
  task automatic send_request(
    input logic               op,
    input logic [ID_W-1:0]    id,
    input logic [CODE_W-1:0]  code,
    input logic [QTY_W-1:0]   qty,
    input logic [PRICE_W-1:0] price
  );
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                 : $urandom_range(1, 10);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_order_id      <= id;
    in_priority_code <= code;
    in_quantity      <= qty;
    in_unit_price    <= price;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  initial begin
    stim_mode_t  mode;
    int          seg_len;
    int          deq_pct;
    logic [7:0]  focus_code;
    logic [7:0]  code;
    int          sel;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty queue, invalid codes, field extremes and tie order.
    send_request(OP_DEQ, '0, 8'd1, '0, '0);
    send_request(OP_ENQ, {ID_W{1'b1}}, 8'd1, {QTY_W{1'b1}}, {PRICE_W{1'b1}});
    send_request(OP_ENQ, '0, 8'd0, '0, '0);
    send_request(OP_ENQ, 31'd1, 8'd255, 20'd1, 32'd1);
    send_request(OP_ENQ, 31'h2AAA_AAAA, 8'd3, 20'h55555, 32'hAAAA_AAAA);
    send_request(OP_ENQ, 31'h5555_5555, 8'd2, 20'hAAAAA, 32'h5555_5555);
    send_request(OP_ENQ, 31'd7, 8'd4, {QTY_W{1'b1}}, 32'd3);
    send_request(OP_ENQ, 31'd8, 8'd1, 20'd2, {PRICE_W{1'b1}});
    send_request(OP_ENQ, 31'd9, 8'd128, 20'd5, 32'd6);
    repeat (8) begin
      send_request(OP_DEQ, {ID_W{1'b1}}, 8'hFF, {QTY_W{1'b1}}, {PRICE_W{1'b1}});
    end
    send_request(OP_DEQ, '0, 8'd0, '0, '0);
    send_request(OP_ENQ, 31'd10, 8'd3, 20'd11, 32'd12);
    send_request(OP_ENQ, 31'd11, 8'd2, 20'd13, 32'd14);
    send_request(OP_DEQ, '0, 8'd3, '0, '0);
    send_request(OP_DEQ, '0, 8'd3, '0, '0);
    send_request(OP_DEQ, '0, 8'd3, '0, '0);

    // Random part in segments that mix, fill, drain or flood one rank.
    while (items_sent < RANDOM_ITEMS) begin
      mode    = stim_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(16, 64);
      if (seg_len > RANDOM_ITEMS - items_sent) seg_len = RANDOM_ITEMS - items_sent;
      case ($urandom_range(0, 3))
        0:       focus_code = 8'd1;
        1:       focus_code = 8'd2;
        2:       focus_code = 8'd3;
        default: focus_code = 8'($urandom_range(4, 255));
      endcase
      case (mode)
        MIX_MODE:   deq_pct = 50;
        FILL_MODE:  deq_pct = 15;
        DRAIN_MODE: deq_pct = 80;
        default:    deq_pct = 5;
      endcase
      repeat (seg_len) begin
        sel = $urandom_range(0, 15);
        if (mode == FLOOD_MODE && sel < 14) begin
          code = focus_code;
        end else if (sel < 4) begin
          code = 8'd1;
        end else if (sel < 8) begin
          code = 8'd3;
        end else if (sel < 11) begin
          code = 8'd2;
        end else begin
          code = 8'($urandom_range(0, 255));
        end
        send_request(($urandom_range(0, 99) < deq_pct) ? OP_DEQ : OP_ENQ,
                     ID_W'(biased_value(32'h7FFF_FFFF)), code,
                     QTY_W'(biased_value(32'h000F_FFFF)),
                     biased_value(32'hFFFF_FFFF));
      end
    end

    // Wait for every owed result, then for any stray one.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> three_level_stable_priority_queue.f
design/tlpq_pkg.sv
design/tlpq_ctrl.sv
design/tlpq_dp.sv
design/three_level_stable_priority_queue.sv
tb/tlpq_order_checker.sv
tb/tb_three_level_stable_priority_queue.sv
